// File: rtl/core/serial_frame_deframer_xor_check_defines.svh
// -----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Concurrent assertion helpers shared by the deframer RTL.
// -----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_XOR_CHECK_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_XOR_CHECK_DEFINES_SVH

`ifndef SYNTH
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/sfd_pkg.sv
// -----------------------------------------------------------------------------
// Serial frame deframer package
// Frame bytes, field positions, status codes and shared types.
// -----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 100;

    localparam logic [7:0] HEAD_BYTE = 8'h8B;
    localparam logic [7:0] TAIL_BYTE = 8'h8D;
    localparam logic [7:0] TYPE_ACK  = 8'hAA;
    localparam logic [7:0] TYPE_DATA = 8'hAB;

    // Byte positions within a frame, the head being position 0.
    localparam int unsigned POS_TYPE   = 1;
    localparam int unsigned POS_X      = 2;
    localparam int unsigned POS_Y_HIGH = 3;
    localparam int unsigned POS_Y_LOW  = 4;
    localparam int unsigned POS_CHECK  = 5;
    localparam int unsigned POS_TAIL   = 6;

    typedef enum logic [2:0] {
        ST_ACK       = 3'd0,
        ST_DATA      = 3'd1,
        ST_CHECK_ERR = 3'd2,
        ST_LEN_ERR   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [7:0]         x_value;
        logic signed [15:0] y_value;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/sfd_rx_if.sv
// -----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received serial byte per word.
// -----------------------------------------------------------------------------
`default_nettype none

interface sfd_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// File: rtl/core/sfd_res_if.sv
// -----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel that carries one decoded frame result per word.
// -----------------------------------------------------------------------------
`default_nettype none

interface sfd_res_if;

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         x_value;
    logic signed [15:0] y_value;

    modport source (output valid, output status, output x_value, output y_value,
                    input ready);
    modport sink (input valid, input status, input x_value, input y_value,
                  output ready);

endinterface

`default_nettype wire

// File: rtl/core/sfd_frame_track.sv
// -----------------------------------------------------------------------------
// Frame tracker
// Holds the hunt and collect state and decides a frame when its tail arrives.
// -----------------------------------------------------------------------------
`default_nettype none

module sfd_frame_track
    import sfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_res,
    output logic            o_in_frame
);

    localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CntW-1:0] LastCnt = CntW'(MAX_FRAME_BYTES - 1);

    logic            r_in_frame, n_in_frame;
    logic [CntW-1:0] r_count, n_count;
    logic [7:0]      r_xor, n_xor;
    logic [7:0]      r_type, n_type;
    logic [7:0]      r_x, n_x;
    logic [7:0]      r_y_high, n_y_high;
    logic [7:0]      r_y_low, n_y_low;
    logic [7:0]      r_check, n_check;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_count       = r_count;
        n_xor         = r_xor;
        n_type        = r_type;
        n_x           = r_x;
        n_y_high      = r_y_high;
        n_y_low       = r_y_low;
        n_check       = r_check;
        o_res.valid   = 1'b0;
        o_res.status  = ST_ACK;
        o_res.x_value = '0;
        o_res.y_value = '0;
        if (i_step) begin
            if (!r_in_frame) begin
                if (i_byte == HEAD_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = CntW'(1);
                    n_xor      = i_byte;
                end
            end else if (r_count >= LastCnt) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                n_xor      = '0;
            end else if (i_byte != TAIL_BYTE) begin
                case (r_count)
                    CntW'(POS_TYPE):   n_type   = i_byte;
                    CntW'(POS_X):      n_x      = i_byte;
                    CntW'(POS_Y_HIGH): n_y_high = i_byte;
                    CntW'(POS_Y_LOW):  n_y_low  = i_byte;
                    CntW'(POS_CHECK):  n_check  = i_byte;
                    default: ;
                endcase
                if (r_count <= CntW'(POS_Y_LOW)) begin
                    n_xor = r_xor ^ i_byte;
                end
                n_count = r_count + CntW'(1);
            end else begin
                o_res.valid = 1'b1;
                if (r_count != CntW'(POS_TAIL)) begin
                    o_res.status = ST_LEN_ERR;
                end else if (r_xor != r_check) begin
                    o_res.status = ST_CHECK_ERR;
                end else if (r_type == TYPE_ACK) begin
                    o_res.status = ST_ACK;
                end else if (r_type == TYPE_DATA) begin
                    o_res.status  = ST_DATA;
                    o_res.x_value = r_x;
                    o_res.y_value = {r_y_high, r_y_low};
                end else begin
                    o_res.status = ST_UNKNOWN;
                end
                n_in_frame = 1'b0;
                n_count    = '0;
                n_xor      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_xor      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_xor      <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_x      <= n_x;
        r_y_high <= n_y_high;
        r_y_low  <= n_y_low;
        r_check  <= n_check;
    end

    assign o_in_frame = r_in_frame;

endmodule

`default_nettype wire

// File: rtl/core/serial_frame_deframer_xor_check.sv
// -----------------------------------------------------------------------------
// Serial frame deframer with XOR check
// Hunts for head/tail framed serial bytes and reports one result per frame of fewer than MAX_FRAME_BYTES bytes.
// -----------------------------------------------------------------------------
// Received bytes enter on i_rx, one byte per word; frame results leave on
// o_res with a status code and, for data frames, the x and y values.
// Every byte passes an input register and then the frame tracker, whose
// decision for a tail byte is loaded into the output register. A result is
// therefore offered once its tail byte has passed both registers.
// One byte is taken every cycle as long as the output register is free or
// is being emptied in the same cycle; bytes that end no frame use no slot
// downstream. When the receiver stalls with a result pending, the input
// register fills and i_rx.ready drops after at most one more byte.
// Reset clears the valid flags of both registers and returns the tracker to
// hunting for a head byte; the frame field bytes are not reset and need no clearing pass.
// -----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_deframer_xor_check_defines.svh"

module serial_frame_deframer_xor_check
    import sfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfd_rx_if.sink     i_rx,
    sfd_res_if.source  o_res
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [7:0]         r_out_x;
    logic signed [15:0] r_out_y;

    logic    w_out_free;
    logic    w_step;
    logic    w_in_accept;
    logic    w_in_frame;
    t_result w_res;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_step      = r_in_valid && w_out_free;
    assign i_rx.ready  = !r_in_valid || w_out_free;
    assign w_in_accept = i_rx.valid && i_rx.ready;

    sfd_frame_track #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .o_res      (w_res),
        .o_in_frame (w_in_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= w_res.valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_step && w_res.valid) begin
            r_out_status <= w_res.status;
            r_out_x      <= w_res.x_value;
            r_out_y      <= w_res.y_value;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.x_value = r_out_x;
    assign o_res.y_value = r_out_y;

    `SFD_ASSERT_NEXT(a_hunt_after_tail, i_clk, i_rst_n, w_step && w_res.valid, !w_in_frame)
    `SFD_ASSERT_SAME(a_status_range, i_clk, i_rst_n, w_step && w_res.valid,
                     w_res.status <= ST_UNKNOWN)
    `SFD_ASSERT_SAME(a_values_only_data, i_clk, i_rst_n, r_out_valid && r_out_status != ST_DATA,
                     r_out_x == 8'd0 && r_out_y == 16'sd0)
    `SFD_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_step && w_res.valid, r_out_valid)

endmodule

`default_nettype wire
